// ===== src/rte_pkg.sv =====
package rte_pkg;

   // fixed point scaling of the smoothed estimates
   localparam int FRAC_BITS = 3;

   localparam int RTT_W    = 20;
   localparam int RTO_W    = 22;
   localparam int FLOOR_W  = 16;
   localparam int SHIFT_W  = 3;
   localparam int STATE_W  = 24;
   localparam int WHOLE_W  = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [STATE_W-1:0] STATE_MAX = {STATE_W{1'b1}};
   localparam logic [RTO_W-1:0]   RTO_MAX   = {RTO_W{1'b1}};

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 3'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd6;

   // item kinds
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_RTO_INITIAL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RTO_FLOOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RTO_CEILING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_SHIFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_SHIFT    = 3'd5;

   // register reset values
   localparam logic [RTO_W-1:0]   RST_RTO_INITIAL   = 22'd1200;
   localparam logic [FLOOR_W-1:0] RST_RTO_FLOOR     = 16'd300;
   localparam logic [RTO_W-1:0]   RST_RTO_CEILING   = 22'd60000;
   localparam logic [RTO_W-1:0]   RST_BACKOFF_LIMIT = 22'd30000;
   localparam logic [SHIFT_W-1:0] RST_ALPHA_SHIFT   = 3'd3;
   localparam logic [SHIFT_W-1:0] RST_BETA_SHIFT    = 3'd2;

endpackage

// ===== src/rte_if.sv =====
interface rte_req_if
   import rte_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [RTT_W-1:0] rtt_ms;

   modport source (output valid, output kind, output rtt_ms, input ready);
   modport sink   (input valid, input kind, input rtt_ms, output ready);
endinterface

interface rte_rsp_if
   import rte_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [RTO_W-1:0]   rto_ms;
   logic [WHOLE_W-1:0] srtt_whole;
   logic [WHOLE_W-1:0] rttvar_whole;
   logic               first_sample;

   modport source (output valid, output rto_ms, output srtt_whole, output rttvar_whole,
                   output first_sample, input ready);
   modport sink   (input valid, input rto_ms, input srtt_whole, input rttvar_whole,
                   input first_sample, output ready);
endinterface

interface rte_csr_if
   import rte_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/retransmit_timeout_estimator_core.sv =====
// retransmission timeout estimator: every request beat is either an rtt sample
// (kind 0, rtt in ms) or a timeout expiry (kind 1), and yields exactly one
// response beat with the timeout now in force, the whole-ms parts of the
// smoothed rtt and of the rtt variation, and a flag for a start-up sample.
// the first nonzero sample seeds the estimate; later samples update it as
// exponential averages with power-of-two gains and clamp the timeout between
// floor and ceiling; an expiry doubles the timeout up to the backoff limit.
// a beat is held in the input register and worked out from there, landing in
// the response register; one beat is taken every cycle while the response
// side is not stalled, each beat's estimator update using the state left by
// the one before. csr writes are taken at any time out of reset but must only be
// issued while no beat is in flight.
module retransmit_timeout_estimator_core
   import rte_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   rte_req_if.sink   req_bus,
   rte_rsp_if.source rsp_bus,
   rte_csr_if.sink   csr_bus
);

   localparam int WIDE_W = 32;
   localparam int SUM_W  = STATE_W + 3;
   localparam int UPD_W  = STATE_W + 1;

   // input register
   logic             in_vld_ff;
   logic             in_kind_ff;
   logic [RTT_W-1:0] in_rtt_ff;

   // response register
   logic               out_vld_ff;
   logic [RTO_W-1:0]   out_rto_ff;
   logic [WHOLE_W-1:0] out_srtt_ff;
   logic [WHOLE_W-1:0] out_rttvar_ff;
   logic               out_first_ff;

   // estimator state
   logic [STATE_W-1:0] srtt_ff, srtt_in;
   logic [STATE_W-1:0] rttvar_ff, rttvar_in;
   logic [RTO_W-1:0]   rto_ff, rto_in;
   logic               first_in;

   // configuration
   logic [FLOOR_W-1:0] rto_floor_ff;
   logic [RTO_W-1:0]   rto_ceiling_ff;
   logic [RTO_W-1:0]   backoff_limit_ff;
   logic [SHIFT_W-1:0] alpha_shift_ff;
   logic [SHIFT_W-1:0] beta_shift_ff;

   logic advance;
   logic csr_fire;
   logic rto_load;

   // datapath intermediates
   logic [WIDE_W-1:0]  scaled_wide;
   logic [STATE_W-1:0] scaled;
   logic [SHIFT_W-1:0] gain_a, gain_b;
   logic [STATE_W-1:0] err;
   logic [UPD_W-1:0]   v_upd, s_upd;
   logic [STATE_W-1:0] v_next, s_next;
   logic [SUM_W-1:0]   sum, whole, floored;
   logic [RTO_W:0]     doubled;

   // a beat moves on when the response slot is free or being drained
   assign advance       = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!in_vld_ff || advance);
   assign csr_bus.ready = !reset;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   // no estimate yet, so a new start value applies at once
   assign rto_load = csr_fire && (csr_bus.index == CSR_RTO_INITIAL) && (srtt_ff == '0);

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.rto_ms       = out_rto_ff;
   assign rsp_bus.srtt_whole   = out_srtt_ff;
   assign rsp_bus.rttvar_whole = out_rttvar_ff;
   assign rsp_bus.first_sample = out_first_ff;

   always_comb begin
      // sample in fixed point, saturated to the state width
      scaled_wide = WIDE_W'(in_rtt_ff) << FRAC_BITS;
      if (scaled_wide > WIDE_W'(STATE_MAX)) begin
         scaled = STATE_MAX;
      end else begin
         scaled = scaled_wide[STATE_W-1:0];
      end

      // gains held inside their legal range
      gain_a = alpha_shift_ff;
      if (gain_a < SHIFT_MIN) gain_a = SHIFT_MIN;
      if (gain_a > SHIFT_MAX) gain_a = SHIFT_MAX;
      gain_b = beta_shift_ff;
      if (gain_b < SHIFT_MIN) gain_b = SHIFT_MIN;
      if (gain_b > SHIFT_MAX) gain_b = SHIFT_MAX;

      err = (srtt_ff > scaled) ? (srtt_ff - scaled) : (scaled - srtt_ff);

      // smoothed update, one extra bit to catch overflow
      v_upd = UPD_W'(rttvar_ff) - (UPD_W'(rttvar_ff) >> gain_b) + (UPD_W'(err) >> gain_b);
      s_upd = UPD_W'(srtt_ff) - (UPD_W'(srtt_ff) >> gain_a) + (UPD_W'(scaled) >> gain_a);
      v_next = v_upd[UPD_W-1] ? STATE_MAX : v_upd[STATE_W-1:0];
      s_next = s_upd[UPD_W-1] ? STATE_MAX : s_upd[STATE_W-1:0];

      doubled = {rto_ff, 1'b0};

      srtt_in   = srtt_ff;
      rttvar_in = rttvar_ff;
      rto_in    = rto_ff;
      first_in  = 1'b0;

      if (in_kind_ff == KIND_SAMPLE && srtt_ff == '0) begin
         // start-up: srtt = sample, rttvar = half of it
         srtt_in   = scaled;
         rttvar_in = scaled >> 1;
         first_in  = 1'b1;
      end else if (in_kind_ff == KIND_SAMPLE) begin
         srtt_in   = s_next;
         rttvar_in = v_next;
      end

      // rto = srtt + 4 * rttvar, back to whole ms
      sum     = SUM_W'(srtt_in) + (SUM_W'(rttvar_in) << 2);
      whole   = sum >> FRAC_BITS;
      floored = (whole < SUM_W'(rto_floor_ff)) ? SUM_W'(rto_floor_ff) : whole;

      if (in_kind_ff == KIND_TIMEOUT) begin
         // back off: double and cap
         if (doubled > (RTO_W+1)'(backoff_limit_ff)) begin
            rto_in = backoff_limit_ff;
         end else begin
            rto_in = doubled[RTO_W-1:0];
         end
      end else if (first_in) begin
         rto_in = (floored > SUM_W'(RTO_MAX)) ? RTO_MAX : floored[RTO_W-1:0];
      end else begin
         // ceiling applied last, so it wins over the floor
         rto_in = (floored > SUM_W'(rto_ceiling_ff)) ? rto_ceiling_ff
                                                     : floored[RTO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         out_vld_ff       <= 1'b0;
         srtt_ff          <= '0;
         rttvar_ff        <= '0;
         rto_ff           <= RST_RTO_INITIAL;
         rto_floor_ff     <= RST_RTO_FLOOR;
         rto_ceiling_ff   <= RST_RTO_CEILING;
         backoff_limit_ff <= RST_BACKOFF_LIMIT;
         alpha_shift_ff   <= RST_ALPHA_SHIFT;
         beta_shift_ff    <= RST_BETA_SHIFT;
      end else begin
         // input register
         if (req_bus.ready) begin
            in_vld_ff <= req_bus.valid;
         end

         // response register
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end

         if (advance) begin
            srtt_ff   <= srtt_in;
            rttvar_ff <= rttvar_in;
         end

         if (rto_load) begin
            rto_ff <= csr_bus.data[RTO_W-1:0];
         end else if (advance) begin
            rto_ff <= rto_in;
         end

         if (csr_fire) begin
            unique case (csr_bus.index)
               CSR_RTO_INITIAL: begin
                  // only acts on the live timeout, through rto_load
               end
               CSR_RTO_FLOOR:     rto_floor_ff     <= csr_bus.data[FLOOR_W-1:0];
               CSR_RTO_CEILING:   rto_ceiling_ff   <= csr_bus.data[RTO_W-1:0];
               CSR_BACKOFF_LIMIT: backoff_limit_ff <= csr_bus.data[RTO_W-1:0];
               CSR_ALPHA_SHIFT:   alpha_shift_ff   <= csr_bus.data[SHIFT_W-1:0];
               CSR_BETA_SHIFT:    beta_shift_ff    <= csr_bus.data[SHIFT_W-1:0];
               default: begin
               end
            endcase
         end
      end

      // payload registers, no reset
      if (req_bus.ready) begin
         in_kind_ff <= req_bus.kind;
         in_rtt_ff  <= req_bus.rtt_ms;
      end
      if (advance) begin
         out_rto_ff    <= rto_in;
         out_srtt_ff   <= srtt_in[FRAC_BITS +: WHOLE_W];
         out_rttvar_ff <= rttvar_in[FRAC_BITS +: WHOLE_W];
         out_first_ff  <= first_in;
      end
   end

endmodule
